/* hw/rtl/mesh_vertex_dedup_indexer_top_defines.svh */
// ----------------------------------------------------------------------------
// Mesh vertex dedup indexer assertion macros
// Shared property wrappers for the concurrent checks of the indexer.
// ----------------------------------------------------------------------------
`ifndef MESH_VERTEX_DEDUP_INDEXER_TOP_DEFINES_SVH
`define MESH_VERTEX_DEDUP_INDEXER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MVDI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mvdi check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MVDI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mvdi check failed");

`endif

/* hw/rtl/mvdi_pkg.sv */
// ----------------------------------------------------------------------------
// Mesh vertex dedup indexer package
// Command codes, emit codes and the control/status structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvdi_pkg;

    // Input command codes carried in the input tuser.
    localparam logic [1:0] CMD_LOAD_POS = 2'd0;
    localparam logic [1:0] CMD_LOAD_NRM = 2'd1;
    localparam logic [1:0] CMD_CORNER   = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    // Result word selection driven by the controller.
    localparam logic [2:0] EMIT_NONE = 3'd0;
    localparam logic [2:0] EMIT_HIT  = 3'd1;
    localparam logic [2:0] EMIT_FULL = 3'd2;
    localparam logic [2:0] EMIT_VTX  = 3'd3;
    localparam logic [2:0] EMIT_IDX  = 3'd4;

    // Result kinds.
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    // Field geometry.
    localparam int IDX_W     = 21;
    localparam int KEY_W     = 3 * IDX_W;
    localparam int WORD_W    = 32;
    localparam int ID_W      = 12;
    localparam int ID_LIMIT  = 4096;
    localparam int CNT_W     = 13;
    localparam int IN_DATA_W = 184;
    localparam int OUT_DATA_W = 208;
    localparam logic [7:0] TRI_SIZE = 8'd3;

    // Register indexes on the configuration port.
    localparam logic REG_POS_COUNT = 1'b0;
    localparam logic REG_NRM_COUNT = 1'b1;

    typedef struct packed {
        logic       accept;
        logic       start;
        logic       scan_en;
        logic       insert;
        logic [2:0] emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tri;
        logic hit;
        logic scan_done;
        logic full;
        logic out_free;
        logic over_cap;
    } t_dp_sts;

endpackage

/* hw/rtl/mesh_vertex_dedup_indexer_top.sv */
// Loads, clear commands and corners of non-triangles are taken in the idle state.
// A triangle corner scans the key table one filled entry per cycle from id 0:
// a hit returns the matching id, a miss adds a new vertex record and index
// entry or a full-table report; the single key table read port sets the scan rate.
// One item is in flight at a time. Reset clears the unique count and control;
// the stores and key table are not cleared and take no clearing pass.
// ----------------------------------------------------------------------------
// Mesh vertex dedup indexer top level
// Streaming corner deduplicator with an APB register port for store counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mesh_vertex_dedup_indexer_top_defines.svh"

module mesh_vertex_dedup_indexer_top #(
    parameter int ATTR_DEPTH  = 4096,
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slot, word_x, word_y, word_z, position index, normal index,
    // texture index, face_size (low bit up), zero filled
    input  logic [mvdi_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // command
    input  logic [1:0]                      i_s_tuser,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // vertex_id, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z (low bit up), zero filled
    output logic [mvdi_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // kind, table_full (low bit up)
    output logic [1:0]                      o_m_tuser,
    output logic                            o_m_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import mvdi_pkg::*;

    logic [CNT_W-1:0] r_pos_count;
    logic [CNT_W-1:0] r_nrm_count;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    // Count registers on the configuration port.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_count <= '0;
            r_nrm_count <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_POS_COUNT) begin
                r_pos_count <= pwdata[CNT_W-1:0];
            end else begin
                r_nrm_count <= pwdata[CNT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_POS_COUNT) ? {19'd0, r_pos_count}
                                                : {19'd0, r_nrm_count};

    // Controller.
    mvdi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    mvdi_datapath #(
        .ATTR_DEPTH  (ATTR_DEPTH),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_user   (i_s_tuser),
        .i_in_data   (i_s_tdata),
        .i_pos_count (r_pos_count),
        .i_nrm_count (r_nrm_count),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // Checks.
    `MVDI_ASSERT_NOW(a_full_is_last_index, o_m_tvalid && o_m_tuser[1], o_m_tlast && o_m_tuser[0])
    `MVDI_ASSERT_NOW(a_vertex_not_last, o_m_tvalid && !o_m_tuser[0], !o_m_tlast)
    `MVDI_ASSERT_NOW(a_count_in_cap, 1'b1, !sts.over_cap)
    `MVDI_ASSERT_NEXT(a_insert_then_vertex, cmd.insert, !o_s_tready)

endmodule

/* hw/rtl/mvdi_ctrl.sv */
// ----------------------------------------------------------------------------
// Mesh vertex dedup indexer controller
// Sequences the key scan, insertion and result words of one corner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvdi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mvdi_pkg::t_dp_sts i_sts,
    output mvdi_pkg::t_dp_cmd o_cmd
);
    import mvdi_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_HIT  = 3'd2;
    localparam logic [2:0] ST_MISS = 3'd3;
    localparam logic [2:0] ST_VTX  = 3'd4;
    localparam logic [2:0] ST_IDX  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next-state and command decode.
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.accept  = 1'b0;
        o_cmd.start   = 1'b0;
        o_cmd.scan_en = 1'b0;
        o_cmd.insert  = 1'b0;
        o_cmd.emit    = EMIT_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_sts.is_tri) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // The scan stops on a hit so that the matching id is held.
                if (i_sts.hit) begin
                    n_state = ST_HIT;
                end else begin
                    o_cmd.scan_en = 1'b1;
                    if (i_sts.scan_done) begin
                        n_state = ST_MISS;
                    end
                end
            end
            ST_HIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = EMIT_HIT;
                    n_state    = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (i_sts.full) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit = EMIT_FULL;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    o_cmd.insert = 1'b1;
                    n_state      = ST_VTX;
                end
            end
            ST_VTX: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = EMIT_VTX;
                    n_state    = ST_IDX;
                end
            end
            ST_IDX: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = EMIT_IDX;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/mvdi_datapath.sv */
// ----------------------------------------------------------------------------
// Mesh vertex dedup indexer datapath
// Attribute stores, key table scan, unique counter and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvdi_datapath #(
    parameter int ATTR_DEPTH  = 4096,
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mvdi_pkg::t_dp_cmd              i_cmd,
    output mvdi_pkg::t_dp_sts              o_sts,
    input  logic [1:0]                     i_in_user,
    input  logic [mvdi_pkg::IN_DATA_W-1:0] i_in_data,
    input  logic [mvdi_pkg::CNT_W-1:0]     i_pos_count,
    input  logic [mvdi_pkg::CNT_W-1:0]     i_nrm_count,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [mvdi_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [1:0]                     o_m_tuser,
    output logic                           o_m_tlast
);
    import mvdi_pkg::*;

    localparam int CAP = (TABLE_DEPTH < ID_LIMIT) ? TABLE_DEPTH : ID_LIMIT;
    localparam int CAW = $clog2(CAP);
    localparam int CW  = CAW + 1;
    localparam int AW  = $clog2(ATTR_DEPTH);

    // Input field slices.
    logic [11:0]       in_slot;
    logic [WORD_W-1:0] in_wx, in_wy, in_wz;
    logic [IDX_W-1:0]  in_pidx, in_nidx;
    logic [KEY_W-1:0]  in_key;
    logic [7:0]        in_face;
    assign in_slot = i_in_data[11:0];
    assign in_wx   = i_in_data[43:12];
    assign in_wy   = i_in_data[75:44];
    assign in_wz   = i_in_data[107:76];
    assign in_pidx = i_in_data[128:108];
    assign in_nidx = i_in_data[149:129];
    assign in_key  = i_in_data[170:108];
    assign in_face = i_in_data[178:171];

    logic [31:0] slot_ext;
    logic        slot_ok;
    logic        pos_ok, nrm_ok;
    assign slot_ext = {20'd0, in_slot};
    assign slot_ok  = slot_ext < 32'(ATTR_DEPTH);
    assign pos_ok   = !in_pidx[IDX_W-1]
                      && ({1'b0, in_pidx[IDX_W-2:0]} < {8'd0, i_pos_count})
                      && ({11'd0, in_pidx} < 32'(ATTR_DEPTH));
    assign nrm_ok   = !in_nidx[IDX_W-1]
                      && ({1'b0, in_nidx[IDX_W-2:0]} < {8'd0, i_nrm_count})
                      && ({11'd0, in_nidx} < 32'(ATTR_DEPTH));

    // Attribute stores, one memory per component.
    logic [WORD_W-1:0] pos_x_mem [ATTR_DEPTH];
    logic [WORD_W-1:0] pos_y_mem [ATTR_DEPTH];
    logic [WORD_W-1:0] pos_z_mem [ATTR_DEPTH];
    logic [WORD_W-1:0] nrm_x_mem [ATTR_DEPTH];
    logic [WORD_W-1:0] nrm_y_mem [ATTR_DEPTH];
    logic [WORD_W-1:0] nrm_z_mem [ATTR_DEPTH];
    logic [KEY_W-1:0]  key_mem   [CAP];

    logic [AW-1:0]     r_pos_addr, r_nrm_addr;
    logic              r_pos_ok, r_nrm_ok;
    logic [KEY_W-1:0]  r_key;
    logic [WORD_W-1:0] r_px, r_py, r_pz, r_nx, r_ny, r_nz;

    // Store writes on load words.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && slot_ok && i_in_user == CMD_LOAD_POS) begin
            pos_x_mem[slot_ext[AW-1:0]] <= in_wx;
            pos_y_mem[slot_ext[AW-1:0]] <= in_wy;
            pos_z_mem[slot_ext[AW-1:0]] <= in_wz;
        end
        if (i_cmd.accept && slot_ok && i_in_user == CMD_LOAD_NRM) begin
            nrm_x_mem[slot_ext[AW-1:0]] <= in_wx;
            nrm_y_mem[slot_ext[AW-1:0]] <= in_wy;
            nrm_z_mem[slot_ext[AW-1:0]] <= in_wz;
        end
        r_px <= pos_x_mem[r_pos_addr];
        r_py <= pos_y_mem[r_pos_addr];
        r_pz <= pos_z_mem[r_pos_addr];
        r_nx <= nrm_x_mem[r_nrm_addr];
        r_ny <= nrm_y_mem[r_nrm_addr];
        r_nz <= nrm_z_mem[r_nrm_addr];
    end

    // Corner key and fetch addresses latched on every accepted word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key      <= in_key;
            r_pos_addr <= in_pidx[AW-1:0];
            r_nrm_addr <= in_nidx[AW-1:0];
            r_pos_ok   <= pos_ok;
            r_nrm_ok   <= nrm_ok;
        end
    end

    // Key table scan over the filled entries, one entry per cycle.
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_ptr;
    logic             r_rd_vld;
    logic [CAW-1:0]   r_rd_id;
    logic [KEY_W-1:0] r_rd_key;
    logic [ID_W-1:0]  r_new_id;

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            key_mem[r_count[CAW-1:0]] <= r_key;
            r_new_id <= ID_W'(r_count);
        end
        r_rd_key <= key_mem[r_ptr[CAW-1:0]];
        if (i_cmd.scan_en) begin
            r_rd_id <= r_ptr[CAW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.accept && i_in_user == CMD_CLEAR) begin
                r_count <= '0;
            end else if (i_cmd.insert) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.start) begin
                r_ptr    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_en) begin
                r_rd_vld <= r_ptr < r_count;
                if (r_ptr < r_count) begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
        end
    end

    // Result register: holds one word until the sink takes it.
    logic r_ov;
    logic out_free;
    assign out_free = !r_ov || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit != EMIT_NONE) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.emit)
            EMIT_HIT: begin
                o_m_tdata <= {{(OUT_DATA_W-ID_W){1'b0}}, ID_W'(r_rd_id)};
                o_m_tuser <= {1'b0, KIND_INDEX};
                o_m_tlast <= 1'b1;
            end
            EMIT_FULL: begin
                o_m_tdata <= '0;
                o_m_tuser <= {1'b1, KIND_INDEX};
                o_m_tlast <= 1'b1;
            end
            EMIT_VTX: begin
                o_m_tdata <= {4'd0,
                              r_nrm_ok ? r_nz : 32'd0,
                              r_nrm_ok ? r_ny : 32'd0,
                              r_nrm_ok ? r_nx : 32'd0,
                              r_pos_ok ? r_pz : 32'd0,
                              r_pos_ok ? r_py : 32'd0,
                              r_pos_ok ? r_px : 32'd0,
                              r_new_id};
                o_m_tuser <= {1'b0, KIND_VERTEX};
                o_m_tlast <= 1'b0;
            end
            EMIT_IDX: begin
                o_m_tdata <= {{(OUT_DATA_W-ID_W){1'b0}}, r_new_id};
                o_m_tuser <= {1'b0, KIND_INDEX};
                o_m_tlast <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_ov;

    // Status back to the controller.
    assign o_sts.is_tri    = (i_in_user == CMD_CORNER) && (in_face == TRI_SIZE);
    assign o_sts.hit       = r_rd_vld && (r_rd_key == r_key);
    assign o_sts.scan_done = !r_rd_vld && (r_ptr >= r_count);
    assign o_sts.full      = r_count >= CW'(CAP);
    assign o_sts.out_free  = out_free;
    assign o_sts.over_cap  = r_count > CW'(CAP);

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// Mesh vertex dedup indexer testbench
// Streams load, corner and clear words into the indexer. A behavioral model
// of the key table and the attribute stores predicts the vertex records and
// index entries, and every output word is checked field by field. Several
// count settings and idle/stall mixes are covered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import mvdi_pkg::*;

    localparam int DEPTH     = 4096;
    localparam int WDOG_MAX  = 50000;

    typedef struct {
        logic [1:0]  cmd;
        logic [11:0] slot;
        logic [31:0] wx, wy, wz;
        logic [20:0] pidx, nidx, tidx;
        logic [7:0]  fsize;
    } cmd_word_t;

    typedef struct {
        logic        kind;
        logic [11:0] vid;
        logic [31:0] pos [3];
        logic [31:0] nrm [3];
        logic        last;
        logic        full;
    } result_word_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel, penable, pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    mesh_vertex_dedup_indexer_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser), .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser), .o_m_tlast(m_tlast),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Stimulus and prediction state.
    cmd_word_t    pending_words[$];
    result_word_t expected_results[$];
    logic [31:0]  pos_store [3*DEPTH];
    logic [31:0]  nrm_store [3*DEPTH];
    bit           gen_pos_loaded [DEPTH];
    bit           gen_nrm_loaded [DEPTH];
    int           key_ids [bit [62:0]];
    int           unique_count;
    int           pos_count, nrm_count;
    int           send_idle_pct, recv_stall_pct;
    int           errors, wdog, n_in, n_out, n_vertex, n_full;
    bit           took;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Append a word to the stimulus queue.
    function automatic void queue_word(input cmd_word_t c);
        pending_words.insert(pending_words.size(), c);
    endfunction

    // Append a result to the prediction queue.
    function automatic void queue_result(input result_word_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // Three words of one attribute entry, or zeros when the index is invalid.
    function automatic void fetch_entry(input bit is_pos, input logic [20:0] idx,
                                        output logic [31:0] w [3]);
        int cnt;
        cnt = is_pos ? pos_count : nrm_count;
        for (int k = 0; k < 3; k++) w[k] = '0;
        if (!idx[20] && idx < cnt && idx < DEPTH)
            for (int k = 0; k < 3; k++)
                w[k] = is_pos ? pos_store[3*idx+k] : nrm_store[3*idx+k];
    endfunction

    // Update the store and table model with one accepted word and queue
    // the results it causes.
    task automatic predict_corner(input cmd_word_t c);
        result_word_t r;
        bit [62:0] key;
        r.kind = KIND_INDEX; r.vid = '0; r.last = 1'b1; r.full = 1'b0;
        for (int k = 0; k < 3; k++) begin r.pos[k] = '0; r.nrm[k] = '0; end
        case (c.cmd)
            CMD_LOAD_POS: begin
                pos_store[3*c.slot] = c.wx; pos_store[3*c.slot+1] = c.wy;
                pos_store[3*c.slot+2] = c.wz;
            end
            CMD_LOAD_NRM: begin
                nrm_store[3*c.slot] = c.wx; nrm_store[3*c.slot+1] = c.wy;
                nrm_store[3*c.slot+2] = c.wz;
            end
            CMD_CLEAR: begin
                key_ids.delete();
                unique_count = 0;
            end
            default: begin
                if (c.fsize == TRI_SIZE) begin
                    key = {c.tidx, c.nidx, c.pidx};
                    if (key_ids.exists(key)) begin
                        r.vid = 12'(key_ids[key]);
                        queue_result(r);
                    end else if (unique_count >= ID_LIMIT) begin
                        r.full = 1'b1;
                        queue_result(r);
                    end else begin
                        key_ids[key] = unique_count;
                        r.vid = 12'(unique_count);
                        r.kind = KIND_VERTEX; r.last = 1'b0;
                        fetch_entry(1'b1, c.pidx, r.pos);
                        fetch_entry(1'b0, c.nidx, r.nrm);
                        queue_result(r);
                        r.kind = KIND_INDEX; r.last = 1'b1;
                        for (int k = 0; k < 3; k++) begin r.pos[k] = '0; r.nrm[k] = '0; end
                        queue_result(r);
                        unique_count++;
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: mismatch on %s, expected %h, got %h", $time, name,
                     exp_v, act_v);
            errors++;
        end
    endtask

    // Input acceptance, output checking and the watchdog.
    always @(posedge i_clk) begin
        result_word_t e;
        if (i_rst_n) begin
            wdog = wdog + 1;
            if (s_tvalid && s_tready) begin
                took = 1'b1;
                n_in++;
                wdog = 0;
                predict_corner('{cmd: s_tuser, slot: s_tdata[11:0], wx: s_tdata[43:12],
                    wy: s_tdata[75:44], wz: s_tdata[107:76], pidx: s_tdata[128:108],
                    nidx: s_tdata[149:129], tidx: s_tdata[170:150],
                    fsize: s_tdata[178:171]});
            end
            if (m_tvalid && m_tready) begin
                wdog = 0;
                n_out++;
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected output word, got %h", $time, m_tdata);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (e.kind == KIND_VERTEX) n_vertex++;
                    if (e.full) n_full++;
                    check_field("kind", e.kind, m_tuser[0]);
                    check_field("table_full", e.full, m_tuser[1]);
                    check_field("last", e.last, m_tlast);
                    check_field("vertex_id", e.vid, m_tdata[11:0]);
                    check_field("pos_x", e.pos[0], m_tdata[43:12]);
                    check_field("pos_y", e.pos[1], m_tdata[75:44]);
                    check_field("pos_z", e.pos[2], m_tdata[107:76]);
                    check_field("nrm_x", e.nrm[0], m_tdata[139:108]);
                    check_field("nrm_y", e.nrm[1], m_tdata[171:140]);
                    check_field("nrm_z", e.nrm[2], m_tdata[203:172]);
                    check_field("pad", '0, m_tdata[207:204]);
                end
            end
            if (wdog >= WDOG_MAX) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Input driver and output back-pressure, both on the falling edge.
    always @(negedge i_clk) begin
        cmd_word_t c;
        logic nxt_valid;
        logic [IN_DATA_W-1:0] nxt_data;
        logic [1:0] nxt_user;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        nxt_user  = s_tuser;
        if (took) begin
            nxt_valid = 1'b0;
            took = 1'b0;
        end
        if (i_rst_n && !nxt_valid && pending_words.size() > 0 &&
            $urandom_range(0, 99) >= send_idle_pct) begin
            c = pending_words.pop_front();
            nxt_valid = 1'b1;
            nxt_user  = c.cmd;
            nxt_data  = {5'b0, c.fsize, c.tidx, c.nidx, c.pidx, c.wz, c.wy, c.wx, c.slot};
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
        s_tuser  <= nxt_user;
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Register write through the setup and access cycles.
    task automatic write_reg(input logic idx, input int value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_POS_COUNT) pos_count = value;
        else nrm_count = value;
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_counts(input int pc, input int nc);
        wait_drained();
        write_reg(REG_POS_COUNT, pc);
        write_reg(REG_NRM_COUNT, nc);
    endtask

    // An attribute index that never reaches an unloaded entry under the
    // count in force.
    function automatic logic [20:0] pick_index(input bit is_pos);
        logic [20:0] v;
        int cnt;
        cnt = is_pos ? pos_count : nrm_count;
        case ($urandom_range(0, 9))
            0: v = '1;
            1: v = 21'($urandom);
            2: v = 21'h0FFFFF;
            default: v = 21'($urandom_range(0, 15));
        endcase
        if (!v[20] && v < cnt && v < DEPTH &&
            !(is_pos ? gen_pos_loaded[v] : gen_nrm_loaded[v]))
            v = '1;
        return v;
    endfunction

    function automatic cmd_word_t make_load(input logic [1:0] cmd, input int slot,
                                            input logic [31:0] w);
        cmd_word_t c;
        c = '{cmd: cmd, slot: 12'(slot), wx: w, wy: ~w, wz: $urandom,
              pidx: 21'($urandom), nidx: 21'($urandom), tidx: 21'($urandom),
              fsize: 8'($urandom)};
        if (cmd == CMD_LOAD_POS) gen_pos_loaded[slot] = 1'b1;
        else gen_nrm_loaded[slot] = 1'b1;
        return c;
    endfunction

    function automatic cmd_word_t make_corner(input logic [20:0] p, input logic [20:0] n,
                                              input logic [20:0] t, input logic [7:0] fs);
        return '{cmd: CMD_CORNER, slot: 12'($urandom), wx: $urandom, wy: $urandom,
                 wz: $urandom, pidx: p, nidx: n, tidx: t, fsize: fs};
    endfunction

    function automatic cmd_word_t make_clear();
        cmd_word_t c;
        c = make_corner(21'($urandom), 21'($urandom), 21'($urandom), 8'($urandom));
        c.cmd = CMD_CLEAR;
        return c;
    endfunction

    // Random mix: mostly triangle corners over a small index range so that
    // hits are common, with loads, clears and other face sizes in between.
    task automatic random_phase(input int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                queue_word(make_load(r[0] ? CMD_LOAD_NRM : CMD_LOAD_POS,
                    ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15)
                                               : $urandom_range(0, DEPTH-1), $urandom));
            else if (r < 18)
                queue_word(make_clear());
            else if (r < 24)
                queue_word(make_corner(pick_index(1), pick_index(0),
                    21'($urandom_range(0, 3)),
                    r[0] ? 8'd255 : 8'($urandom_range(0, 8))));
            else
                queue_word(make_corner(pick_index(1), pick_index(0),
                    ($urandom_range(0, 9) == 0) ? 21'($urandom)
                                                : 21'($urandom_range(0, 3)),
                    TRI_SIZE));
        end
    endtask

    initial begin
        int pct_idle [4] = '{0, 87, 0, 35};
        int pct_stall [4] = '{0, 0, 87, 35};
        int pc_set [4] = '{4096, 3, 1, 4096};
        int nc_set [4] = '{4096, 4095, 0, 1};
        i_rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        took = 1'b0; wdog = 0; errors = 0; n_in = 0; n_out = 0;
        n_vertex = 0; n_full = 0; unique_count = 0; pos_count = 0; nrm_count = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: store extremes, zero counts, odd face sizes, hits
        // and a clear.
        set_counts(0, 0);
        queue_word(make_load(CMD_LOAD_POS, 0, 32'hFFFF_FFFF));
        queue_word(make_load(CMD_LOAD_NRM, 0, 32'h0000_0000));
        queue_word(make_load(CMD_LOAD_POS, DEPTH-1, 32'h3F80_0000));
        queue_word(make_load(CMD_LOAD_NRM, DEPTH-1, 32'hBF80_0000));
        queue_word(make_corner(21'd0, 21'd0, 21'd0, TRI_SIZE));
        queue_word(make_corner(21'd0, 21'd0, 21'd0, TRI_SIZE));
        queue_word(make_corner('1, '1, '1, TRI_SIZE));
        queue_word(make_corner(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF, TRI_SIZE));
        queue_word(make_corner(21'h100000, 21'h100000, 21'h100000, TRI_SIZE));
        queue_word(make_corner(21'd5, 21'd5, 21'd5, 8'd0));
        queue_word(make_corner(21'd5, 21'd5, 21'd5, 8'd4));
        queue_word(make_corner(21'd5, 21'd5, 21'd5, 8'd255));
        set_counts(4096, 4096);
        queue_word(make_corner(21'd0, 21'd0, 21'd1, TRI_SIZE));
        queue_word(make_corner(21'd4095, 21'd4095, 21'd1, TRI_SIZE));
        queue_word(make_corner(21'd4096, 21'd0, 21'd1, TRI_SIZE));
        queue_word(make_corner(21'd4095, 21'd4095, 21'd1, TRI_SIZE));
        queue_word(make_clear());
        queue_word(make_corner(21'd4095, 21'd4095, 21'd1, TRI_SIZE));
        queue_word(make_load(CMD_LOAD_POS, 1, $urandom));
        queue_word(make_load(CMD_LOAD_NRM, 1, $urandom));
        queue_word(make_corner(21'd1, 21'd1, 21'd1, TRI_SIZE));

        // Random part, one idle/stall mix and count setting per phase.
        for (int ph = 0; ph < 4; ph++) begin
            set_counts(pc_set[ph], nc_set[ph]);
            send_idle_pct = pct_idle[ph];
            recv_stall_pct = pct_stall[ph];
            random_phase(170);
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("Run covered %0d input words and %0d output words over four idle mixes,",
                 n_in, n_out);
        $display("with %0d new vertices and %0d full-table reports.", n_vertex, n_full);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mvdi_pkg.sv
hw/rtl/mvdi_ctrl.sv
hw/rtl/mvdi_datapath.sv
hw/rtl/mesh_vertex_dedup_indexer_top.sv
tb/sv/tb.sv
